FILE: hw/rtl/trbba_pkg.sv
package trbba_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned OFF_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [OFF_BITS-1:0]  t_off;
    typedef logic [1:0]           t_req;
    typedef logic [1:0]           t_status;

    localparam t_req REQ_ALLOC_INODE = 2'd0;
    localparam t_req REQ_ALLOC_DATA  = 2'd1;
    localparam t_req REQ_FREE_INODE  = 2'd2;
    localparam t_req REQ_FREE_DATA   = 2'd3;

    localparam t_status STATUS_DONE     = 2'd0;
    localparam t_status STATUS_NO_SPACE = 2'd1;
    localparam t_status STATUS_IGNORED  = 2'd2;

    localparam int unsigned INODE_COUNT  = 160;
    localparam int unsigned INODE_SKEW   = 5;
    localparam int unsigned REGION_SPLIT = INODE_COUNT + INODE_SKEW;
    localparam int unsigned SPLIT_WORD   = REGION_SPLIT / WORD_BITS;
    localparam int unsigned SPLIT_OFF    = REGION_SPLIT % WORD_BITS;

    localparam t_word ALL_ONES        = '1;
    localparam t_word TOP_BIT         = 32'h8000_0000;
    localparam t_word DATA_HEAD_MASK  = ALL_ONES >> SPLIT_OFF;
    localparam t_word INODE_TAIL_MASK = ~DATA_HEAD_MASK;
    localparam t_word FORMAT_WORD0    = ALL_ONES >> INODE_SKEW;

endpackage

FILE: hw/rtl/trbba_bitmap_ram.sv
module trbba_bitmap_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  trbba_pkg::t_word     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output trbba_pkg::t_word     o_rdata
);

    trbba_pkg::t_word r_mem [DEPTH];
    trbba_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/trbba_lead_one.sv
module trbba_lead_one (
    input  trbba_pkg::t_word i_word,
    output logic             o_found,
    output trbba_pkg::t_off  o_pos
);

    // Position counts from the most significant bit, which is the lowest block.
    always_comb begin
        o_pos = '0;
        for (int p = trbba_pkg::WORD_BITS - 1; p >= 0; p--) begin
            if (i_word[trbba_pkg::WORD_BITS - 1 - p]) begin
                o_pos = trbba_pkg::t_off'(p);
            end
        end
    end

    assign o_found = |i_word;

endmodule

FILE: hw/rtl/two_region_bitmap_block_allocator.sv
// Channel    Direction  Handshake                       Payload
// request    in         i_req_valid / o_req_ready       i_req_type, i_target_index
// response   out        o_rsp_valid / i_rsp_ready       o_granted_index, o_status
//
// An allocation scans the bitmap one word per cycle through a single leading-one
// finder: an inode from word 0 up to the split word, a data block from the split
// word up to the last word. A free is a read-modify-write of one word; an ignored
// free goes straight to the response.
// After reset a formatting pass writes every word, one a cycle, before the first
// item is taken. The block takes one item at a time and holds its response until
// it is taken.
module two_region_bitmap_block_allocator #(
    parameter int unsigned NUM_BLOCKS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_target_index,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [11:0] o_granted_index,
    output logic [1:0]  o_status
);

    localparam int unsigned NUM_WORDS =
        (NUM_BLOCKS + trbba_pkg::WORD_BITS - 1) / trbba_pkg::WORD_BITS;
    localparam int unsigned AW        = $clog2(NUM_WORDS);
    localparam int unsigned IW        = AW + trbba_pkg::OFF_BITS;
    localparam int unsigned LAST_BITS =
        NUM_BLOCKS - trbba_pkg::WORD_BITS * (NUM_WORDS - 1);
    localparam trbba_pkg::t_word LAST_MASK = ~(trbba_pkg::ALL_ONES >> LAST_BITS);
    localparam logic [AW-1:0] LAST_WORD  = AW'(NUM_WORDS - 1);
    localparam logic [AW-1:0] SPLIT_WORD = AW'(trbba_pkg::SPLIT_WORD);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FRD  = 3'd3;
    localparam logic [2:0] S_FWR  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [AW-1:0]       r_addr;
    logic                r_data_region;
    logic                r_data_vld;
    logic [AW-1:0]       r_data_addr;
    trbba_pkg::t_off     r_off;
    logic [11:0]         r_granted;
    trbba_pkg::t_status  r_status;

    trbba_pkg::t_word    rd_data;
    trbba_pkg::t_word    scan_mask;
    trbba_pkg::t_word    scan_word;
    logic                scan_found;
    trbba_pkg::t_off     scan_pos;
    logic [AW-1:0]       end_word;
    logic                scan_hit;
    logic                scan_miss;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    trbba_pkg::t_word    ram_wdata;

    logic                req_fire;
    logic                req_alloc;
    logic                free_bad;
    logic [IW-1:0]       free_bit;

    assign o_req_ready     = (r_state == S_IDLE);
    assign o_rsp_valid     = (r_state == S_DONE);
    assign o_granted_index = r_granted;
    assign o_status        = r_status;

    assign req_fire  = i_req_valid && o_req_ready;
    assign req_alloc = (i_req_type == trbba_pkg::REQ_ALLOC_INODE) ||
                       (i_req_type == trbba_pkg::REQ_ALLOC_DATA);

    always_comb begin
        if (i_req_type == trbba_pkg::REQ_FREE_INODE) begin
            free_bad = (32'(i_target_index) >= trbba_pkg::INODE_COUNT);
            free_bit = IW'(i_target_index) + IW'(trbba_pkg::INODE_SKEW);
        end else begin
            free_bad = (32'(i_target_index) < trbba_pkg::INODE_COUNT) ||
                       (32'(i_target_index) >= NUM_BLOCKS);
            free_bit = IW'(i_target_index);
        end
    end

    // Only the bits of the word that lie inside the requested region take part.
    always_comb begin
        scan_mask = trbba_pkg::ALL_ONES;
        if (r_data_addr == SPLIT_WORD) begin
            scan_mask = r_data_region ? trbba_pkg::DATA_HEAD_MASK
                                      : trbba_pkg::INODE_TAIL_MASK;
        end
        if (r_data_region && (r_data_addr == LAST_WORD)) begin
            scan_mask = scan_mask & LAST_MASK;
        end
    end

    assign scan_word = rd_data & scan_mask;
    assign end_word  = r_data_region ? LAST_WORD : SPLIT_WORD;
    assign scan_hit  = (r_state == S_SCAN) && r_data_vld && scan_found;
    assign scan_miss = (r_state == S_SCAN) && r_data_vld && !scan_found &&
                       (r_data_addr == end_word);

    trbba_lead_one u_lead_one (
        .i_word  (scan_word),
        .o_found (scan_found),
        .o_pos   (scan_pos)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = trbba_pkg::ALL_ONES;
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = (r_addr == '0) ? trbba_pkg::FORMAT_WORD0 : trbba_pkg::ALL_ONES;
            end
            S_SCAN: begin
                ram_we    = scan_hit;
                ram_waddr = r_data_addr;
                ram_wdata = rd_data & ~(trbba_pkg::TOP_BIT >> scan_pos);
            end
            S_FWR: begin
                ram_we    = 1'b1;
                ram_wdata = rd_data | (trbba_pkg::TOP_BIT >> r_off);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    trbba_bitmap_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    if (req_alloc) begin
                        n_state = S_SCAN;
                    end else if (free_bad) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FRD;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_miss) begin
                    n_state = S_DONE;
                end
            end
            S_FRD: begin
                n_state = S_FWR;
            end
            S_FWR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_addr     <= '0;
            r_data_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLR: begin
                    if (r_addr != LAST_WORD) begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    r_data_vld <= 1'b0;
                    if (req_fire) begin
                        if (req_alloc) begin
                            r_addr <= (i_req_type == trbba_pkg::REQ_ALLOC_DATA) ? SPLIT_WORD
                                                                                 : '0;
                        end else begin
                            r_addr <= free_bit[IW-1:trbba_pkg::OFF_BITS];
                        end
                    end
                end
                S_SCAN: begin
                    // Reads run one word ahead of the check; the last word is re-read
                    // harmlessly until the check reaches it.
                    r_data_vld <= 1'b1;
                    if (r_addr != end_word) begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                default: begin
                    r_data_vld <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_addr <= r_addr;
        if (req_fire) begin
            r_data_region <= (i_req_type == trbba_pkg::REQ_ALLOC_DATA);
            r_off         <= free_bit[trbba_pkg::OFF_BITS-1:0];
            r_granted     <= '0;
            r_status      <= (!req_alloc && free_bad) ? trbba_pkg::STATUS_IGNORED
                                                      : trbba_pkg::STATUS_DONE;
        end else if (scan_hit) begin
            r_granted <= 12'({r_data_addr, scan_pos});
            r_status  <= trbba_pkg::STATUS_DONE;
        end else if (scan_miss) begin
            r_granted <= '0;
            r_status  <= trbba_pkg::STATUS_NO_SPACE;
        end
    end

endmodule
